/* design/mcu_pkg.sv */
package mcu_pkg;

  localparam int unsigned MAX_STAGES_DEF = 4;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned NUM_COEF  = 4;
  localparam int unsigned COEF_W    = 17;
  localparam int unsigned SC_W      = 3;
  localparam int unsigned TS_W      = 32;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned ACC_W     = 40;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned T_W       = COEF_W + TS_W - FRAC_BITS;
  localparam int unsigned CHUNK_W   = 16;
  localparam int unsigned Q_W       = 63;

  localparam logic [COEF_W-1:0] COEF0_RST = 17'd65536;
  localparam logic [COEF_W-1:0] COEFN_RST = 17'd0;
  localparam logic [SC_W-1:0]   SC_RST    = 3'd1;
  localparam logic [TS_W-1:0]   TS_RST    = 32'd65536;

  typedef enum logic [IDX_W-1:0] {
    REG_COEF0       = 3'd0,
    REG_COEF1       = 3'd1,
    REG_COEF2       = 3'd2,
    REG_COEF3       = 3'd3,
    REG_STAGE_COUNT = 3'd4,
    REG_TIME_STEP   = 3'd5
  } reg_idx_e;

  typedef enum logic {
    OP_FACE    = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [NUM_COEF-1:0][COEF_W-1:0] coef;
    logic [SC_W-1:0]                 stage_count;
    logic [TS_W-1:0]                 time_step;
  } cfg_t;

  typedef struct packed {
    logic face_acc;
    logic last_load;
    logic adv;
    logic prep;
    logic mul_step;
    logic div_step;
    logic fin_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // (a mod n) for a <= 8, 1 <= n <= 8
  function automatic logic [3:0] mod_small(input logic [3:0] a, input logic [3:0] n);
    logic [3:0] r;
    r = a;
    for (int i = 0; i < 8; i++) begin
      if (r >= n) begin
        r = r - n;
      end
    end
    return r;
  endfunction

endpackage

/* design/mcu_cfg.sv */
module mcu_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mcu_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [mcu_pkg::DATA_W-1:0] cfg_data_i,
  output mcu_pkg::cfg_t              cfg_o
);

  mcu_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        [mcu_pkg::REG_COEF0:mcu_pkg::REG_COEF3]: begin
          cfg_d.coef[cfg_idx_i[1:0]] = cfg_data_i[mcu_pkg::COEF_W-1:0];
        end
        mcu_pkg::REG_STAGE_COUNT: begin
          cfg_d.stage_count = cfg_data_i[mcu_pkg::SC_W-1:0];
        end
        mcu_pkg::REG_TIME_STEP: begin
          cfg_d.time_step = cfg_data_i[mcu_pkg::TS_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef[0]     <= mcu_pkg::COEF0_RST;
      cfg_q.coef[1]     <= mcu_pkg::COEFN_RST;
      cfg_q.coef[2]     <= mcu_pkg::COEFN_RST;
      cfg_q.coef[3]     <= mcu_pkg::COEFN_RST;
      cfg_q.stage_count <= mcu_pkg::SC_RST;
      cfg_q.time_step   <= mcu_pkg::TS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/mcu_ctrl.sv */
module mcu_ctrl #(
  parameter int unsigned VALUE_BITS = mcu_pkg::VALUE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           op_i,
  input  logic           last_face_i,
  input  mcu_pkg::stat_t stat_i,
  output logic           in_ready_o,
  output mcu_pkg::cmd_t  cmd_o
);

  localparam int unsigned NCH = (VALUE_BITS + mcu_pkg::CHUNK_W - 1) / mcu_pkg::CHUNK_W;
  localparam int unsigned PW  = mcu_pkg::T_W + VALUE_BITS;
  localparam int unsigned CW  = $clog2(PW);

  mcu_pkg::state_e state_d, state_q;
  logic [CW-1:0]   cnt_d, cnt_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      mcu_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (op_i == mcu_pkg::OP_ADVANCE) begin
            cmd_o.adv = 1'b1;
          end else begin
            cmd_o.face_acc = 1'b1;
            if (last_face_i) begin
              cmd_o.last_load = 1'b1;
              state_d         = mcu_pkg::ST_PREP;
            end
          end
        end
      end
      mcu_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = CW'(NCH - 1);
        state_d    = mcu_pkg::ST_MUL;
      end
      mcu_pkg::ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (cnt_q == '0) begin
          cnt_d   = CW'(PW - 1);
          state_d = mcu_pkg::ST_DIV;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      mcu_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = mcu_pkg::ST_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      mcu_pkg::ST_FIN: begin
        // hold here while the output register is still occupied
        if (stat_i.out_free) begin
          cmd_o.fin_load = 1'b1;
          state_d        = mcu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mcu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcu_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* design/mcu_dp.sv */
module mcu_dp #(
  parameter int unsigned MAX_STAGES = mcu_pkg::MAX_STAGES_DEF,
  parameter int unsigned VALUE_BITS = mcu_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mcu_pkg::cmd_t                      cmd_i,
  input  mcu_pkg::cfg_t                      cfg_i,
  input  logic signed [mcu_pkg::FIELD_W-1:0] flux_i,
  input  logic signed [mcu_pkg::FIELD_W-1:0] source_i,
  input  logic signed [mcu_pkg::FIELD_W-1:0] old_value_i,
  input  logic        [mcu_pkg::FIELD_W-1:0] volume_i,
  input  logic                               out_ready_i,
  output mcu_pkg::stat_t                     stat_o,
  output logic                               out_valid_o,
  output logic signed [mcu_pkg::FIELD_W-1:0] new_value_o,
  output logic signed [mcu_pkg::FIELD_W-1:0] residual_o,
  output logic                               saturated_o
);

  localparam int unsigned VB    = VALUE_BITS;
  localparam int unsigned ACC_W = mcu_pkg::ACC_W;
  localparam int unsigned FW    = mcu_pkg::FIELD_W;
  localparam int unsigned T_W   = mcu_pkg::T_W;
  localparam int unsigned Q_W   = mcu_pkg::Q_W;
  localparam int unsigned CH_W  = mcu_pkg::CHUNK_W;
  localparam int unsigned SI_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int unsigned RES_W = ((VB > ACC_W) ? VB : ACC_W) + 2;
  localparam int unsigned NCH   = (VB + CH_W - 1) / CH_W;
  localparam int unsigned MAG_W = NCH * CH_W;
  localparam int unsigned PW    = T_W + VB;
  localparam int unsigned NV_W  = Q_W + 2;
  localparam int unsigned TP_W  = mcu_pkg::COEF_W + mcu_pkg::TS_W;

  localparam logic signed [RES_W-1:0] RMAX = {{(RES_W-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RMIN = ~RMAX;
  localparam logic signed [NV_W-1:0]  NMAX = {{(NV_W-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [NV_W-1:0]  NMIN = ~NMAX;
  localparam logic [3:0]              MAXS = 4'(MAX_STAGES);

  // control state
  logic signed [ACC_W-1:0] acc_d, acc_q;
  logic [SI_W-1:0]         si_d, si_q;
  logic                    out_valid_d, out_valid_q;

  // operands and working registers
  logic signed [FW-1:0] src_q, old_q;
  logic [FW-1:0]        vol_q;
  logic [T_W-1:0]       t_q;
  logic signed [VB-1:0] res_q;
  logic                 res_sat_q;
  logic [MAG_W-1:0]     mag_q;
  logic [PW-1:0]        prod_q;
  logic [FW-1:0]        rem_q;
  logic [Q_W-1:0]       quo_q;
  logic                 ovf_q;
  logic signed [FW-1:0] new_value_q, residual_q;
  logic                 sat_q;

  // accumulator
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_clip;

  assign acc_sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(flux_i);

  always_comb begin
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_clip = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_clip = acc_sum[ACC_W-1:0];
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.face_acc) begin
      acc_d = acc_clip;
    end else if (cmd_i.prep) begin
      acc_d = '0;
    end
  end

  // stage index
  logic [3:0]                  sc4, n_eff, si4, si_next;
  logic [mcu_pkg::COEF_W-1:0] coef_sel;

  always_comb begin
    sc4 = {1'b0, cfg_i.stage_count};
    if (sc4 == 4'd0) begin
      n_eff = 4'd1;
    end else if (sc4 > MAXS) begin
      n_eff = MAXS;
    end else begin
      n_eff = sc4;
    end
    si4     = 4'(si_q);
    si_next = mcu_pkg::mod_small(si4 + 4'd1, n_eff);
    si_d    = cmd_i.adv ? si_next[SI_W-1:0] : si_q;
    coef_sel = (si4 < 4'(mcu_pkg::NUM_COEF)) ? cfg_i.coef[si4[1:0]] : '0;
  end

  // prep: scaled step and clipped residual
  logic [TP_W-1:0]         tprod;
  logic signed [RES_W-1:0] res_w, res_c, res_abs;
  logic                    res_clip;

  always_comb begin
    tprod    = TP_W'(coef_sel) * TP_W'(cfg_i.time_step);
    res_w    = RES_W'(src_q) - RES_W'(acc_q);
    res_clip = 1'b0;
    res_c    = res_w;
    if (res_w > RMAX) begin
      res_c    = RMAX;
      res_clip = 1'b1;
    end else if (res_w < RMIN) begin
      res_c    = RMIN;
      res_clip = 1'b1;
    end
    res_abs = res_c[RES_W-1] ? -res_c : res_c;
  end

  // multiply, one 16-bit slice of the magnitude per cycle, top slice first
  logic [T_W+CH_W-1:0] pp;
  assign pp = (T_W+CH_W)'(t_q) * (T_W+CH_W)'(mag_q[MAG_W-1 -: CH_W]);

  // restoring divide, one quotient bit per cycle
  logic [FW:0] rsh;
  logic        ge;
  assign rsh = {rem_q, prod_q[PW-1]};
  assign ge  = rsh >= {1'b0, vol_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.last_load) begin
      src_q <= source_i;
      old_q <= old_value_i;
      vol_q <= volume_i;
    end
    if (cmd_i.prep) begin
      t_q       <= tprod[TP_W-1:mcu_pkg::FRAC_BITS];
      res_q     <= res_c[VB-1:0];
      res_sat_q <= res_clip;
      mag_q     <= MAG_W'(res_abs[VB-1:0]);
      prod_q    <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      ovf_q     <= 1'b0;
    end else if (cmd_i.mul_step) begin
      prod_q <= {prod_q[PW-CH_W-1:0], {CH_W{1'b0}}} + PW'(pp);
      mag_q  <= mag_q << CH_W;
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? FW'(rsh - {1'b0, vol_q}) : rsh[FW-1:0];
      prod_q <= prod_q << 1;
      quo_q  <= {quo_q[Q_W-2:0], ge};
      ovf_q  <= ovf_q | quo_q[Q_W-1];
    end
  end

  // finish: apply the update, clip, flag
  logic [Q_W-1:0]         d_cap;
  logic signed [NV_W-1:0] old_ext, d_ext, nv_sum, nv_pre, nv_c;
  logic                   neg, vz, nv_clip;

  always_comb begin
    d_cap   = (ovf_q | quo_q[Q_W-1]) ? (Q_W'(1) << (Q_W - 1)) : quo_q;
    old_ext = NV_W'(old_q);
    d_ext   = {2'b00, d_cap};
    neg     = res_q[VB-1];
    vz      = (vol_q == '0);
    nv_sum  = neg ? (old_ext - d_ext) : (old_ext + d_ext);
    if (vz) begin
      if ((t_q == '0) || (res_q == '0)) begin
        nv_pre = old_ext;
      end else begin
        nv_pre = neg ? NMIN : NMAX;
      end
    end else begin
      nv_pre = nv_sum;
    end
    nv_clip = 1'b0;
    nv_c    = nv_pre;
    if (nv_pre > NMAX) begin
      nv_c    = NMAX;
      nv_clip = 1'b1;
    end else if (nv_pre < NMIN) begin
      nv_c    = NMIN;
      nv_clip = 1'b1;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.fin_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_load) begin
      new_value_q <= nv_c[FW-1:0];
      residual_q  <= FW'(res_q);
      sat_q       <= res_sat_q | vz | nv_clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      si_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      si_q        <= si_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_value_o = new_value_q;
  assign residual_o  = residual_q;
  assign saturated_o = sat_q;

endmodule

/* design/multistage_cell_update.sv */
// Multistage cell update: one stage of a finite-volume time step in Q16.16.
// Input channel (in_valid_i/in_ready_o): op_i = 0 carries one face flux,
// summed into a 40-bit saturating accumulator; the beat with last_face_i
// also brings source, old value and volume, and produces one output beat
// with residual = source - sum and new = old + coef[stage]*dt*residual/vol.
// op_i = 1 steps the stage index modulo the stage count, no output.
// Face beats without last_face_i and advance beats are accepted back to back.
// A last-face beat occupies the block through a prep step, a multiply step
// for each 16-bit slice of |residual|, then a restoring divider producing
// one quotient bit per cycle, which dominates.
// Output channel (out_valid_o/out_ready_i) is a single output register; the
// block keeps accepting while a result waits, and only a following last-face
// beat holds in its finish state until the register frees up.
// Config writes (cfg_we_i/cfg_idx_i/cfg_data_i) take effect at once; write
// only while idle. Reset clears the flux sum, stage index and output valid,
// and loads the register defaults.
module multistage_cell_update #(
  parameter int unsigned MAX_STAGES = mcu_pkg::MAX_STAGES_DEF,
  parameter int unsigned VALUE_BITS = mcu_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mcu_pkg::IDX_W-1:0]          cfg_idx_i,
  input  logic [mcu_pkg::DATA_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               op_i,
  input  logic signed [mcu_pkg::FIELD_W-1:0] flux_i,
  input  logic                               last_face_i,
  input  logic signed [mcu_pkg::FIELD_W-1:0] source_i,
  input  logic signed [mcu_pkg::FIELD_W-1:0] old_value_i,
  input  logic        [mcu_pkg::FIELD_W-1:0] volume_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mcu_pkg::FIELD_W-1:0] new_value_o,
  output logic signed [mcu_pkg::FIELD_W-1:0] residual_o,
  output logic                               saturated_o
);

  mcu_pkg::cfg_t  cfg;
  mcu_pkg::cmd_t  cmd;
  mcu_pkg::stat_t stat;

  mcu_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mcu_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .last_face_i (last_face_i),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  mcu_dp #(
    .MAX_STAGES (MAX_STAGES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .flux_i      (flux_i),
    .source_i    (source_i),
    .old_value_i (old_value_i),
    .volume_i    (volume_i),
    .out_ready_i (out_ready_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .new_value_o (new_value_o),
    .residual_o  (residual_o),
    .saturated_o (saturated_o)
  );

  // a last-face beat starts a computation, so the input closes next cycle
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (op_i == mcu_pkg::OP_FACE) && last_face_i)
    |=> !in_ready_o)
    else $error("input still open after last-face beat");

  // at most one datapath command per cycle, last_load apart
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.face_acc, cmd.adv, cmd.prep, cmd.mul_step, cmd.div_step,
              cmd.fin_load}))
    else $error("overlapping datapath commands");

  // a result is only loaded into a free output register
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fin_load |-> (!out_valid_o || out_ready_i))
    else $error("output register overwritten");

  // output valid rises only from a finished computation
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.fin_load))
    else $error("output beat without computation");

endmodule

/* verif/multistage_cell_update_test.sv */
`timescale 1ns / 1ps

module multistage_cell_update_test;

  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PHASE_BEATS  = 12;
  localparam int unsigned NUM_PHASES   = 6;

  localparam logic [mcu_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [mcu_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam longint ACC_MAX = 64'sh7F_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam longint VAL_MAX = 64'sh7FFF_FFFF;
  localparam longint VAL_MIN = -VAL_MAX - 1;
  localparam logic [127:0] QUO_CAP = 128'h1 << 62;

  typedef struct {
    mcu_pkg::op_e       op;
    logic signed [31:0] flux;
    logic               last_face;
    logic signed [31:0] source;
    logic signed [31:0] old_value;
    logic        [31:0] volume;
  } cell_beat_t;

  typedef struct {
    logic signed [31:0] new_value;
    logic signed [31:0] residual;
    logic               saturated;
  } cell_update_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [mcu_pkg::IDX_W-1:0]  cfg_idx = '0;
  logic [mcu_pkg::DATA_W-1:0] cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       op = 1'b0;
  logic signed [31:0]         flux = '0;
  logic                       last_face = 1'b0;
  logic signed [31:0]         source = '0;
  logic signed [31:0]         old_value = '0;
  logic        [31:0]         volume = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [31:0]         new_value;
  logic signed [31:0]         residual;
  logic                       saturated;

  // shadow of the block's registers and state
  logic [mcu_pkg::COEF_W-1:0] coef_r [mcu_pkg::NUM_COEF] = '{17'd65536, 17'd0, 17'd0, 17'd0};
  logic [mcu_pkg::SC_W-1:0]   count_r = 3'd1;
  logic [mcu_pkg::TS_W-1:0]   dt_r = 32'd65536;
  longint                     flux_acc = 0;
  int unsigned                stage_pos = 0;

  cell_update_t expected_updates[$];
  int unsigned  fail_count = 0;
  bit           tx_burst = 1'b0;
  bit           rx_burst = 1'b0;

  multistage_cell_update DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (op),
    .flux_i      (flux),
    .last_face_i (last_face),
    .source_i    (source),
    .old_value_i (old_value),
    .volume_i    (volume),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .new_value_o (new_value),
    .residual_o  (residual),
    .saturated_o (saturated)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint clip(input longint x, input longint lo, input longint hi,
                                  inout bit hit);
    if (x > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (x < lo) begin
      hit = 1'b1;
      return lo;
    end
    return x;
  endfunction

  task automatic predict_cell_update(input cell_beat_t b);
    cell_update_t               upd;
    bit                         hit;
    bit                         acc_hit;
    int unsigned                n;
    longint                     res;
    longint                     nv;
    longint                     oldv;
    logic [63:0]                t;
    logic [63:0]                mag;
    logic [127:0]               quo;
    logic [mcu_pkg::COEF_W-1:0] c;
    if (b.op == mcu_pkg::OP_ADVANCE) begin
      n = (count_r == 0) ? 1 : ((count_r > mcu_pkg::MAX_STAGES_DEF) ?
                                mcu_pkg::MAX_STAGES_DEF : count_r);
      stage_pos = (stage_pos + 1) % n;
      return;
    end
    acc_hit = 1'b0;
    flux_acc = clip(flux_acc + longint'(b.flux), ACC_MIN, ACC_MAX, acc_hit);
    if (!b.last_face) return;
    hit = 1'b0;
    res = clip(longint'(b.source) - flux_acc, VAL_MIN, VAL_MAX, hit);
    oldv = longint'(b.old_value);
    c = (stage_pos < mcu_pkg::NUM_COEF) ? coef_r[stage_pos] : '0;
    t = (64'(c) * 64'(dt_r)) >> mcu_pkg::FRAC_BITS;
    mag = (res < 0) ? 64'(-res) : 64'(res);
    if (b.volume == 0) begin
      hit = 1'b1;
      if (t == 0 || mag == 0) nv = oldv;
      else nv = (res < 0) ? VAL_MIN : VAL_MAX;
    end else begin
      quo = (128'(t) * 128'(mag)) / 128'(b.volume);
      if (quo > QUO_CAP) quo = QUO_CAP;
      // magnitude takes the residual's sign: rounds toward zero
      nv = (res < 0) ? oldv - longint'(quo[63:0]) : oldv + longint'(quo[63:0]);
      nv = clip(nv, VAL_MIN, VAL_MAX, hit);
    end
    flux_acc = 0;
    upd.new_value = nv[31:0];
    upd.residual  = res[31:0];
    upd.saturated = hit;
    expected_updates.push_back(upd);
  endtask

  function automatic cell_beat_t make_beat(input mcu_pkg::op_e kind, input logic [31:0] f,
                                           input logic last, input logic [31:0] src,
                                           input logic [31:0] old, input logic [31:0] vol);
    cell_beat_t b;
    b.op        = kind;
    b.flux      = f;
    b.last_face = last;
    b.source    = src;
    b.old_value = old;
    b.volume    = vol;
    return b;
  endfunction

  function automatic cell_beat_t advance_beat();
    return make_beat(mcu_pkg::OP_ADVANCE, $urandom, 1'($urandom_range(0, 1)), $urandom,
                     $urandom, $urandom);
  endfunction

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      3, 4: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
      5: return 32'($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_volume();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3: return 32'($urandom_range(1, 32'h0004_0000));
      default: return $urandom;
    endcase
  endfunction

  // one input beat; valid stays high after acceptance until the next call or drain
  task automatic push_beat(input cell_beat_t b);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= b.op;
    flux      <= b.flux;
    last_face <= b.last_face;
    source    <= b.source;
    old_value <= b.old_value;
    volume    <= b.volume;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_cell_update(b);
  endtask

  task automatic write_reg(input logic [mcu_pkg::IDX_W-1:0] idx,
                           input logic [mcu_pkg::DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx) inside
      [mcu_pkg::REG_COEF0:mcu_pkg::REG_COEF3]: begin
        coef_r[idx[1:0]] = data[mcu_pkg::COEF_W-1:0];
      end
      mcu_pkg::REG_STAGE_COUNT: count_r = data[mcu_pkg::SC_W-1:0];
      mcu_pkg::REG_TIME_STEP:   dt_r = data[mcu_pkg::TS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait for all results, then let a trailing face/advance beat settle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_update();
    cell_update_t want;
    if (expected_updates.size() == 0) begin
      $error("unexpected result beat: new_value %0d residual %0d saturated %0b",
             new_value, residual, saturated);
      fail_count++;
      return;
    end
    want = expected_updates.pop_front();
    if (new_value !== want.new_value) begin
      $error("new_value: expected %0d, got %0d", want.new_value, new_value);
      fail_count++;
    end
    if (residual !== want.residual) begin
      $error("residual: expected %0d, got %0d", want.residual, residual);
      fail_count++;
    end
    if (saturated !== want.saturated) begin
      $error("saturated: expected %0b, got %0b", want.saturated, saturated);
      fail_count++;
    end
  endtask

  initial begin : result_monitor
    int unsigned stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 11);
      out_ready <= (stall == 0);
      do @(posedge clk); while (out_valid !== 1'b1);
      if (stall != 0) begin
        repeat (stall - 1) @(posedge clk);
        out_ready <= 1'b1;
        @(posedge clk);
      end
      check_update();
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic test_default_registers();
    // stage count 1: advance keeps stage 0
    push_beat(advance_beat());
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h7FFF_FFFF, 1'b0, $urandom, $urandom, $urandom));
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h8000_0000, 1'b0, $urandom, $urandom, $urandom));
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h0, 1'b1, 32'h0001_0000, 32'h0, 32'h0001_0000));
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h1234_5678, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'hFFFF_FFFF));
  endtask

  task automatic test_zero_volume();
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h0, 1'b1, 32'h0005_0000, 32'd123, 32'h0));
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h0003_0000, 1'b1, 32'h0, -32'sd5, 32'h0));
    // zero residual keeps the old value
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h0002_0000, 1'b1, 32'h0002_0000, -32'sd77,
                        32'h0));
    drain();
    write_reg(mcu_pkg::REG_COEF0, 32'd0);
    // zero step factor keeps the old value
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h0, 1'b1, 32'd7, 32'h8000_0000, 32'h0));
    drain();
    write_reg(mcu_pkg::REG_COEF0, 32'd65536);
  endtask

  task automatic test_clipping();
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h7FFF_FFFF, 1'b0, $urandom, $urandom, $urandom));
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 32'h0, 32'h1));
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h8000_0000, 1'b0, $urandom, $urandom, $urandom));
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'hFFFF_FFFF));
    drain();
    write_reg(mcu_pkg::REG_TIME_STEP, 32'hFFFF_FFFF);
    write_reg(mcu_pkg::REG_COEF0, 32'h0001_FFFF);
    // huge quotient hits the divider cap
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h0, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1));
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h0, 1'b1, -32'sd3, 32'h0, 32'h7FFF_FFFF));
  endtask

  task automatic test_stage_sequencing();
    drain();
    write_reg(mcu_pkg::REG_TIME_STEP, 32'd65536);
    write_reg(mcu_pkg::REG_COEF1, 32'd32768);
    write_reg(mcu_pkg::REG_COEF2, 32'd16384);
    write_reg(mcu_pkg::REG_COEF3, 32'h0001_FFFF);
    write_reg(mcu_pkg::REG_STAGE_COUNT, 32'd4);
    // flux sum survives an advance beat
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h0001_0000, 1'b0, $urandom, $urandom, $urandom));
    push_beat(advance_beat());
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h0, 1'b1, 32'h0008_0000, 32'h0010_0000,
                        32'h0002_0000));
    push_beat(advance_beat());
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h0, 1'b1, 32'h0008_0000, 32'h0010_0000,
                        32'h0002_0000));
    push_beat(advance_beat());
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h0, 1'b1, -32'sh0008_0000, 32'h0,
                        32'h0000_4000));
    push_beat(advance_beat());
    drain();
    // count of zero acts as one
    write_reg(mcu_pkg::REG_STAGE_COUNT, 32'd0);
    push_beat(advance_beat());
    drain();
    // count above the maximum acts as the maximum
    write_reg(mcu_pkg::REG_STAGE_COUNT, 32'd7);
    push_beat(advance_beat());
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h0, 1'b1, 32'h0003_0000, 32'h0, 32'h0001_0000));
    drain();
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h0, 1'b1, 32'h0003_0000, 32'h0, 32'h0001_0000));
  endtask

  task automatic test_accumulator_clip();
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    // drive the 40-bit sum past its upper limit, then back into range
    repeat (257) push_beat(make_beat(mcu_pkg::OP_FACE, 32'h7FFF_FFFF, 1'b0, $urandom,
                                     $urandom, $urandom));
    repeat (256) push_beat(make_beat(mcu_pkg::OP_FACE, 32'h8000_0000, 1'b0, $urandom,
                                     $urandom, $urandom));
    push_beat(make_beat(mcu_pkg::OP_FACE, 32'h0, 1'b1, 32'h0001_0000, pick_q16(),
                        pick_volume()));
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  task automatic test_random_cells();
    int unsigned sent;
    int unsigned faces;
    logic [mcu_pkg::DATA_W-1:0] cv;
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      for (int i = 0; i < mcu_pkg::NUM_COEF; i++) begin
        case ($urandom_range(0, 4))
          0: cv = 32'd0;
          1: cv = 32'd65536;
          2: cv = 32'h0001_FFFF;
          3: cv = $urandom_range(0, 65536);
          default: cv = $urandom;
        endcase
        if (phase == 0) cv = 32'h0001_FFFF;
        if (phase == 1) cv = 32'd0;
        write_reg(mcu_pkg::IDX_W'(mcu_pkg::REG_COEF0 + i), cv);
      end
      cv = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7);
      if (phase == 0) cv = 32'd7;
      if (phase == 1) cv = 32'd0;
      write_reg(mcu_pkg::REG_STAGE_COUNT, cv);
      case ($urandom_range(0, 4))
        0: cv = 32'd0;
        1: cv = 32'd65536;
        2: cv = 32'hFFFF_FFFF;
        3: cv = $urandom_range(0, 32'h0010_0000);
        default: cv = $urandom;
      endcase
      if (phase == 0) cv = 32'hFFFF_FFFF;
      if (phase == 1) cv = 32'd0;
      write_reg(mcu_pkg::REG_TIME_STEP, cv);
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        case ($urandom_range(0, 9))
          0: begin
            push_beat(advance_beat());
            sent++;
          end
          1: begin
            // noise: any op, any last flag
            push_beat(make_beat(mcu_pkg::op_e'($urandom_range(0, 1)), pick_q16(),
                                1'($urandom_range(0, 1)), pick_q16(), pick_q16(),
                                pick_volume()));
            sent++;
          end
          default: begin
            faces = $urandom_range(0, 5);
            repeat (faces) push_beat(make_beat(mcu_pkg::OP_FACE, pick_q16(), 1'b0, $urandom,
                                               $urandom, $urandom));
            push_beat(make_beat(mcu_pkg::OP_FACE, pick_q16(), 1'b1, pick_q16(), pick_q16(),
                                pick_volume()));
            sent += faces + 1;
          end
        endcase
      end
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_default_registers();
    test_zero_volume();
    test_clipping();
    test_stage_sequencing();
    test_accumulator_clip();
    test_random_cells();
    drain();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
design/mcu_pkg.sv
design/mcu_cfg.sv
design/mcu_ctrl.sv
design/mcu_dp.sv
design/multistage_cell_update.sv
verif/multistage_cell_update_test.sv
